### rtl/ppl_pkg.sv
// package for the polyline progress locator
// types, codes and constants shared by controller, datapath and checker
package ppl_pkg;

  localparam int IDX_BITS  = 7;
  localparam int SENS_BITS = 16;
  localparam int TWO_Q8    = 512;

  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_APPEND  = 2'd1,
    OP_QUERY   = 2'd2,
    OP_COMPARE = 2'd3
  } op_code_t;

  typedef enum logic [3:0] {
    A_NONE,
    A_CLEAR,
    A_APPEND,
    A_START,
    A_LATCH,
    A_SQ,
    A_DIR,
    A_SUM,
    A_BEST,
    A_WALK_INIT,
    A_STEP,
    A_RADIUS,
    A_SAVE1,
    A_SAVED,
    A_FIN_Q,
    A_FIN_C
  } alu_op_t;

  typedef enum logic [2:0] {
    ADDR_IDX,
    ADDR_IDX_P1,
    ADDR_IDX_M1,
    ADDR_NXT,
    ADDR_FIRST
  } addr_sel_t;

  typedef enum logic [1:0] {
    DIR_NEXT,
    DIR_PREV,
    DIR_ZERO
  } dir_sel_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_NRD,
    S_NSQ,
    S_NSUM,
    S_NBEST,
    S_WINIT,
    S_WRD,
    S_WLAT,
    S_WMUL,
    S_WSUM,
    S_WSTEP,
    S_RCHK,
    S_RSQ,
    S_RSUM,
    S_RTEST,
    S_QEND,
    S_SECOND,
    S_CRD,
    S_CSQ1,
    S_CSUM1,
    S_CSAVE,
    S_CSQ2,
    S_CSUM2,
    S_CFIN
  } ctl_state_t;

  typedef struct packed {
    alu_op_t   alu;
    logic      rd_en;
    addr_sel_t addr;
    dir_sel_t  dir;
    logic      use_other;
  } dp_cmd_t;

  typedef struct packed {
    logic n_zero;
    logic idx_last;
    logic idx_zero;
    logic dot_neg;
    logic nxt_end;
    logic eq_inside;
  } dp_stat_t;

endpackage

### rtl/ppl_ctrl.sv
// sequencer for the polyline progress locator
// issues datapath commands per cycle; uses ppl_pkg
module ppl_ctrl import ppl_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] in_operation,
  input  dp_stat_t   stat,
  output dp_cmd_t    cmd,
  output logic       busy,
  output logic       out_strobe
);

  ctl_state_t state_r, state_nxt;
  logic       cmp_r, cmp_nxt;
  logic       second_r, second_nxt;
  dir_sel_t   dir_r, dir_nxt;
  logic       strobe_r, strobe_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cmp_r    <= 1'b0;
      second_r <= 1'b0;
      dir_r    <= DIR_ZERO;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cmp_r    <= cmp_nxt;
      second_r <= second_nxt;
      dir_r    <= dir_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmp_nxt       = cmp_r;
    second_nxt    = second_r;
    dir_nxt       = dir_r;
    strobe_nxt    = 1'b0;
    cmd.alu       = A_NONE;
    cmd.rd_en     = 1'b0;
    cmd.addr      = ADDR_IDX;
    cmd.dir       = dir_r;
    cmd.use_other = second_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (op_code_t'(in_operation))
            OP_CLEAR: begin
              cmd.alu    = A_CLEAR;
              strobe_nxt = 1'b1;
            end
            OP_APPEND: begin
              cmd.alu    = A_APPEND;
              strobe_nxt = 1'b1;
            end
            default: begin
              cmd.alu       = A_START;
              cmd.use_other = 1'b0;
              cmp_nxt       = (op_code_t'(in_operation) == OP_COMPARE);
              second_nxt    = 1'b0;
              state_nxt     = stat.n_zero ? S_QEND : S_NRD;
            end
          endcase
        end
      end
      // nearest point scan
      S_NRD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_NSQ;
      end
      S_NSQ: begin
        cmd.alu   = A_SQ;
        state_nxt = S_NSUM;
      end
      S_NSUM: begin
        cmd.alu   = A_SUM;
        state_nxt = S_NBEST;
      end
      S_NBEST: begin
        cmd.alu   = A_BEST;
        state_nxt = stat.idx_last ? S_WINIT : S_NRD;
      end
      // forward walk
      S_WINIT: begin
        cmd.alu   = A_WALK_INIT;
        state_nxt = S_WRD;
      end
      S_WRD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_WLAT;
      end
      S_WLAT: begin
        cmd.alu = A_LATCH;
        if (!stat.idx_last) begin
          cmd.rd_en = 1'b1;
          cmd.addr  = ADDR_IDX_P1;
          dir_nxt   = DIR_NEXT;
        end else if (!stat.idx_zero) begin
          cmd.rd_en = 1'b1;
          cmd.addr  = ADDR_IDX_M1;
          dir_nxt   = DIR_PREV;
        end else begin
          dir_nxt = DIR_ZERO;
        end
        state_nxt = S_WMUL;
      end
      S_WMUL: begin
        cmd.alu   = A_DIR;
        state_nxt = S_WSUM;
      end
      S_WSUM: begin
        cmd.alu   = A_SUM;
        state_nxt = S_WSTEP;
      end
      S_WSTEP: begin
        if (stat.dot_neg) begin
          state_nxt = S_RCHK;
        end else begin
          cmd.alu   = A_STEP;
          state_nxt = stat.idx_last ? S_RCHK : S_WRD;
        end
      end
      // sensitivity radius around the next point
      S_RCHK: begin
        if (stat.nxt_end) begin
          state_nxt = S_QEND;
        end else begin
          cmd.rd_en = 1'b1;
          cmd.addr  = ADDR_NXT;
          state_nxt = S_RSQ;
        end
      end
      S_RSQ: begin
        cmd.alu   = A_SQ;
        state_nxt = S_RSUM;
      end
      S_RSUM: begin
        cmd.alu   = A_SUM;
        state_nxt = S_RTEST;
      end
      S_RTEST: begin
        cmd.alu   = A_RADIUS;
        state_nxt = S_QEND;
      end
      S_QEND: begin
        if (cmp_r && !second_r) begin
          cmd.alu   = A_SAVE1;
          state_nxt = S_SECOND;
        end else if (!cmp_r) begin
          cmd.alu    = A_FIN_Q;
          strobe_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end else if (stat.eq_inside) begin
          state_nxt = S_CRD;
        end else begin
          cmd.alu    = A_FIN_C;
          strobe_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_SECOND: begin
        cmd.alu       = A_START;
        cmd.use_other = 1'b1;
        second_nxt    = 1'b1;
        state_nxt     = stat.n_zero ? S_QEND : S_NRD;
      end
      // tie break on the shared next point
      S_CRD: begin
        cmd.rd_en = 1'b1;
        cmd.addr  = ADDR_FIRST;
        state_nxt = S_CSQ1;
      end
      S_CSQ1: begin
        cmd.alu       = A_SQ;
        cmd.use_other = 1'b0;
        state_nxt     = S_CSUM1;
      end
      S_CSUM1: begin
        cmd.alu   = A_SUM;
        state_nxt = S_CSAVE;
      end
      S_CSAVE: begin
        cmd.alu   = A_SAVED;
        state_nxt = S_CSQ2;
      end
      S_CSQ2: begin
        cmd.alu       = A_SQ;
        cmd.use_other = 1'b1;
        state_nxt     = S_CSUM2;
      end
      S_CSUM2: begin
        cmd.alu   = A_SUM;
        state_nxt = S_CFIN;
      end
      S_CFIN: begin
        cmd.alu    = A_FIN_C;
        strobe_nxt = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = strobe_r;

endmodule

### rtl/ppl_datapath.sv
// datapath of the polyline progress locator: point store, multipliers,
// accumulators, index registers and result registers; uses ppl_pkg
module ppl_datapath import ppl_pkg::*; #(
  parameter int MAX_POINTS = 64,
  parameter int COORD_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic signed [COORD_BITS-1:0] in_pos_x,
  input  logic signed [COORD_BITS-1:0] in_pos_y,
  input  logic signed [COORD_BITS-1:0] in_other_x,
  input  logic signed [COORD_BITS-1:0] in_other_y,
  input  logic                         cfg_we,
  input  logic [SENS_BITS-1:0]         cfg_wdata,
  input  dp_cmd_t                      cmd,
  output dp_stat_t                     stat,
  output logic [IDX_BITS-1:0]          out_next_index,
  output logic                         out_nearer_start,
  output logic [IDX_BITS-1:0]          out_point_count,
  output logic                         out_overflow
);

  localparam int CB = COORD_BITS;
  localparam int AW = $clog2(MAX_POINTS);
  localparam int LW = $clog2(MAX_POINTS + 1);
  localparam int DW = CB + 1;
  localparam int MW = 2 * DW;
  localparam int SW = MW + 1;
  localparam int CW = (SW > 36) ? SW + 1 : 37;

  logic [2*CB-1:0] mem [MAX_POINTS];
  logic [2*CB-1:0] rdata_r;

  logic signed [CB-1:0] px_r, py_r, qx_r, qy_r, ptx_r, pty_r;
  logic signed [MW-1:0] m1_r, m2_r;
  logic signed [SW-1:0] sum_r, bestd_r, d1_r;
  logic [LW-1:0]        len_r, idx_r, best_r, nxt_r, p1_r;
  logic [SENS_BITS-1:0] sens_r;
  logic [CW-1:0]        rhs_r;

  logic signed [CB-1:0] rdx, rdy, posx, posy;
  logic signed [DW-1:0] a1, b1, a2, b2;
  logic signed [MW-1:0] m1_nxt, m2_nxt;
  logic [AW-1:0]        raddr;
  logic [CW-1:0]        lhs;
  logic [SENS_BITS:0]   rad;
  logic [LW:0]          idx_p1;
  logic                 nearer;

  assign rdx  = rdata_r[2*CB-1:CB];
  assign rdy  = rdata_r[CB-1:0];
  assign posx = cmd.use_other ? qx_r : px_r;
  assign posy = cmd.use_other ? qy_r : py_r;

  // operand select: squared offset to the read point, or direction times offset
  always_comb begin
    a1 = DW'(posx) - DW'(rdx);
    b1 = a1;
    a2 = DW'(posy) - DW'(rdy);
    b2 = a2;
    if (cmd.alu == A_DIR) begin
      case (cmd.dir)
        DIR_NEXT: begin
          a1 = DW'(rdx) - DW'(ptx_r);
          a2 = DW'(rdy) - DW'(pty_r);
        end
        DIR_PREV: begin
          a1 = DW'(ptx_r) - DW'(rdx);
          a2 = DW'(pty_r) - DW'(rdy);
        end
        default: begin
          a1 = '0;
          a2 = '0;
        end
      endcase
      b1 = DW'(posx) - DW'(ptx_r);
      b2 = DW'(posy) - DW'(pty_r);
    end
  end

  assign m1_nxt = a1 * b1;
  assign m2_nxt = a2 * b2;

  always_comb begin
    case (cmd.addr)
      ADDR_IDX_P1: raddr = AW'(idx_r + LW'(1));
      ADDR_IDX_M1: raddr = AW'(idx_r - LW'(1));
      ADDR_NXT:    raddr = nxt_r[AW-1:0];
      ADDR_FIRST:  raddr = p1_r[AW-1:0];
      default:     raddr = idx_r[AW-1:0];
    endcase
  end

  assign rad    = (SENS_BITS+1)'(sens_r) + (SENS_BITS+1)'(TWO_Q8);
  assign lhs    = CW'(sum_r) + CW'({sens_r, 8'b0});
  assign idx_p1 = (LW+1)'(idx_r) + (LW+1)'(1);

  always_comb begin
    if (p1_r < nxt_r) begin
      nearer = 1'b1;
    end else if (p1_r > nxt_r) begin
      nearer = 1'b0;
    end else if (p1_r >= len_r) begin
      nearer = 1'b1;
    end else begin
      nearer = (d1_r > sum_r);
    end
  end

  assign stat.n_zero    = (len_r == '0);
  assign stat.idx_last  = (idx_p1 >= (LW+1)'(len_r));
  assign stat.idx_zero  = (idx_r == '0);
  assign stat.dot_neg   = sum_r[SW-1];
  assign stat.nxt_end   = (nxt_r >= len_r);
  assign stat.eq_inside = (p1_r == nxt_r) && (p1_r < len_r);

  always_ff @(posedge clk) begin
    if (cmd.alu == A_APPEND && len_r < LW'(MAX_POINTS)) begin
      mem[len_r[AW-1:0]] <= {in_pos_x, in_pos_y};
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= '0;
      sens_r <= '0;
    end else begin
      if (cfg_we) begin
        sens_r <= cfg_wdata;
      end
      if (cmd.alu == A_CLEAR) begin
        len_r <= '0;
      end else if (cmd.alu == A_APPEND && len_r < LW'(MAX_POINTS)) begin
        len_r <= len_r + LW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    rhs_r <= CW'(rad * rad);
    case (cmd.alu)
      A_CLEAR: begin
        out_next_index   <= '0;
        out_nearer_start <= 1'b0;
        out_point_count  <= '0;
        out_overflow     <= 1'b0;
      end
      A_APPEND: begin
        out_next_index   <= '0;
        out_nearer_start <= 1'b0;
        if (len_r < LW'(MAX_POINTS)) begin
          out_point_count <= IDX_BITS'(len_r + LW'(1));
          out_overflow    <= 1'b0;
        end else begin
          out_point_count <= IDX_BITS'(len_r);
          out_overflow    <= 1'b1;
        end
      end
      A_START: begin
        if (!cmd.use_other) begin
          px_r <= in_pos_x;
          py_r <= in_pos_y;
          qx_r <= in_other_x;
          qy_r <= in_other_y;
        end
        idx_r  <= '0;
        best_r <= '0;
        nxt_r  <= '0;
      end
      A_LATCH: begin
        ptx_r <= rdx;
        pty_r <= rdy;
      end
      A_SQ, A_DIR: begin
        m1_r <= m1_nxt;
        m2_r <= m2_nxt;
      end
      A_SUM: begin
        sum_r <= SW'(m1_r) + SW'(m2_r);
      end
      A_BEST: begin
        if (idx_r == '0 || sum_r < bestd_r) begin
          bestd_r <= sum_r;
          best_r  <= idx_r;
        end
        idx_r <= idx_r + LW'(1);
      end
      A_WALK_INIT: begin
        idx_r <= best_r;
        nxt_r <= best_r;
      end
      A_STEP: begin
        idx_r <= idx_r + LW'(1);
        nxt_r <= idx_r + LW'(1);
      end
      A_RADIUS: begin
        if (lhs < rhs_r) begin
          nxt_r <= nxt_r + LW'(1);
        end
      end
      A_SAVE1: begin
        p1_r <= nxt_r;
      end
      A_SAVED: begin
        d1_r <= sum_r;
      end
      A_FIN_Q: begin
        out_next_index   <= IDX_BITS'(nxt_r);
        out_nearer_start <= 1'b0;
        out_point_count  <= IDX_BITS'(len_r);
        out_overflow     <= 1'b0;
      end
      A_FIN_C: begin
        out_next_index   <= IDX_BITS'(p1_r);
        out_nearer_start <= nearer;
        out_point_count  <= IDX_BITS'(len_r);
        out_overflow     <= 1'b0;
      end
      default: begin
      end
    endcase
  end

endmodule

### rtl/polyline_progress_locator_top.sv
// top level of the polyline progress locator
// joins ppl_ctrl and ppl_datapath; uses ppl_pkg
//
// usage: a command transfers at a rising edge with start high and busy low.
// operation selects clear, append, next-point query or compare. each command
// gives exactly one result, shown for one cycle with out_strobe high.
// clear and append finish at the accept edge: the result shows the next cycle
// and busy never rises, so one may follow every cycle.
// a query scans all stored points for the nearest one, walks forward from it
// and then tests the sensitivity radius around the next point, if one is
// left; a compare runs two queries and, if both give the same next point,
// a tie break. the point store has a single read port, one point per step.
// the result appears in the cycle busy falls; the next command may be taken
// in that same cycle. the receiver cannot stall the block.
// cfg_we writes the sensitivity register; write only while idle.
// reset clears the point count and the sensitivity; the store needs no clear.
module polyline_progress_locator_top import ppl_pkg::*; #(
  parameter int MAX_POINTS = 64,
  parameter int COORD_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   in_operation,
  input  logic signed [COORD_BITS-1:0] in_pos_x,
  input  logic signed [COORD_BITS-1:0] in_pos_y,
  input  logic signed [COORD_BITS-1:0] in_other_x,
  input  logic signed [COORD_BITS-1:0] in_other_y,
  input  logic                         cfg_we,
  input  logic [SENS_BITS-1:0]         cfg_wdata,
  output logic                         out_strobe,
  output logic [IDX_BITS-1:0]          out_next_index,
  output logic                         out_nearer_start,
  output logic [IDX_BITS-1:0]          out_point_count,
  output logic                         out_overflow
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  ppl_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_operation (in_operation),
    .stat         (stat),
    .cmd          (cmd),
    .busy         (busy),
    .out_strobe   (out_strobe)
  );

  ppl_datapath #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_pos_x         (in_pos_x),
    .in_pos_y         (in_pos_y),
    .in_other_x       (in_other_x),
    .in_other_y       (in_other_y),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .cmd              (cmd),
    .stat             (stat),
    .out_next_index   (out_next_index),
    .out_nearer_start (out_nearer_start),
    .out_point_count  (out_point_count),
    .out_overflow     (out_overflow)
  );

endmodule

### rtl/ppl_checker.sv
// port-level checks for the polyline progress locator
// bound to polyline_progress_locator_top; uses ppl_pkg
module ppl_checker import ppl_pkg::*; #(
  parameter int MAX_POINTS = 64
) (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic [1:0]          in_operation,
  input logic                out_strobe,
  input logic [IDX_BITS-1:0] out_point_count,
  input logic                out_overflow
);

  // a long command ends with its result
  a_fall_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_strobe) else $error("busy fell without a result");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy) else $error("result while busy");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_operation == OP_CLEAR) |=>
      (out_strobe && out_point_count == '0 && !out_overflow))
    else $error("clear result wrong");

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_operation == OP_QUERY || in_operation == OP_COMPARE))
      |=> busy) else $error("query did not go busy");

  a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_overflow) |-> out_point_count == IDX_BITS'(MAX_POINTS))
    else $error("overflow while not full");

endmodule

bind polyline_progress_locator_top ppl_checker #(
  .MAX_POINTS (MAX_POINTS)
) u_ppl_checker (.*);
